/* sv/sml_obis_value_extractor_core_assert.svh */
// assertion macros for the obis value extractor
`ifndef SML_OBIS_VALUE_EXTRACTOR_CORE_ASSERT_SVH
`define SML_OBIS_VALUE_EXTRACTOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SOV_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
`define SOV_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define SOV_ASSERT(lbl, ck, rs, prop, msg)
`define SOV_ASSERT_ALWAYS(lbl, ck, prop, msg)
`endif
`endif

/* sv/sov_pkg.sv */
// shared types, constants and helpers of the obis value extractor
package sov_pkg;

  localparam int DEF_BUFFER_DEPTH  = 1024;
  localparam int DEF_SEARCH_WINDOW = 96;
  localparam int CODE_LEN          = 7;
  localparam int NUM_CODES         = 3;
  localparam int IDX_W             = 2;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic ACT_BYTE  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  localparam logic [7:0] SCALER_TAG = 8'h52;
  localparam logic [7:0] INT1_TAG   = 8'h62;
  localparam logic [7:0] INT2_TAG   = 8'h63;
  localparam logic [7:0] INT4_TAG   = 8'h65;
  localparam logic [7:0] INT8_TAG   = 8'h69;

  localparam logic [23:0] MAKER_MARK = 24'h4C475A;

  localparam logic [IDX_W-1:0] IDX_IMPORT = 2'd0;
  localparam logic [IDX_W-1:0] IDX_EXPORT = 2'd1;
  localparam logic [IDX_W-1:0] IDX_POWER  = 2'd2;

  // obis codes, first byte in the top bits
  localparam logic [55:0] CODE_TAB [NUM_CODES] = '{
    56'h07_01_00_01_08_00_FF,
    56'h07_01_00_02_08_00_FF,
    56'h07_01_00_10_07_00_FF
  };

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOC,
    S_CODE,
    S_SCAL,
    S_SCVAL,
    S_INT,
    S_INTB,
    S_NEXT,
    S_OUT
  } scan_state_t;

  // payload length of an integer tag, zero when not an integer tag
  function automatic logic [3:0] int_len(input logic [7:0] tag);
    logic [3:0] n;
    n = 4'd0;
    if (tag == INT1_TAG) n = 4'd1;
    if (tag == INT2_TAG) n = 4'd2;
    if (tag == INT4_TAG) n = 4'd4;
    if (tag == INT8_TAG) n = 4'd8;
    return n;
  endfunction

  // sign extension of an n byte big endian value
  function automatic logic [63:0] sext(input logic [63:0] v, input logic [3:0] n);
    logic [63:0] r;
    r = v;
    if (n == 4'd1) r = {{56{v[7]}}, v[7:0]};
    if (n == 4'd2) r = {{48{v[15]}}, v[15:0]};
    if (n == 4'd4) r = {{32{v[31]}}, v[31:0]};
    return r;
  endfunction

endpackage

/* sv/sov_ram.sv */
// generic single write port ram with registered read
module sov_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/sov_cmd_q.sv */
// short command queue between byte loader and scan engine
module sov_cmd_q #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign empty = (fill == '0);
  assign full  = (fill == CNT_W'(DEPTH));
  assign dout  = slot[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot[wr_ptr] <= din;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + CNT_W'(push && !full) - CNT_W'(pop && !empty);
    end
  end

endmodule

/* sv/sov_front.sv */
// byte loader: stores telegram bytes and queues scan and clear commands
module sov_front #(
  parameter int BUFFER_DEPTH = sov_pkg::DEF_BUFFER_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic                            action,
  input  logic [7:0]                      data_byte,
  input  logic                            last,
  output logic                            ram_we,
  output logic [$clog2(BUFFER_DEPTH)-1:0] ram_waddr,
  output logic [7:0]                      ram_wdata,
  output logic                            cmd_push,
  output logic                            cmd_clr,
  output logic [$clog2(BUFFER_DEPTH+1)-1:0] cmd_cnt
);
  import sov_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);

  logic [CW-1:0] byte_count;
  logic [CW-1:0] byte_count_next;
  logic          has_room;

  assign has_room = (byte_count < CW'(BUFFER_DEPTH));

  // ram write of an accepted telegram byte
  assign ram_we    = accept && (action == ACT_BYTE) && has_room;
  assign ram_waddr = byte_count[AW-1:0];
  assign ram_wdata = data_byte;

  // count after this byte, saturating at the buffer depth
  assign byte_count_next = has_room ? byte_count + 1'b1 : byte_count;

  // command to the scan engine on clear or final byte
  assign cmd_push = accept && ((action == ACT_CLEAR) || last);
  assign cmd_clr  = (action == ACT_CLEAR);
  assign cmd_cnt  = byte_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (accept) begin
      if (action == ACT_CLEAR || last) begin
        byte_count <= '0;
      end else begin
        byte_count <= byte_count_next;
      end
    end
  end

endmodule

/* sv/sov_scan.sv */
// scan engine: locates codes, reads scaler and integer, emits three results
module sov_scan #(
  parameter int BUFFER_DEPTH  = sov_pkg::DEF_BUFFER_DEPTH,
  parameter int SEARCH_WINDOW = sov_pkg::DEF_SEARCH_WINDOW
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  input  logic                              cmd_clr,
  input  logic [$clog2(BUFFER_DEPTH+1)-1:0] cmd_cnt,
  output logic                              cmd_pop,
  output logic [$clog2(BUFFER_DEPTH)-1:0]   rd_addr,
  input  logic [7:0]                        rd_data,
  output logic                              busy,
  output logic                              res_valid,
  output logic [sov_pkg::IDX_W-1:0]         res_index,
  output logic                              res_present,
  output logic signed [63:0]                res_mantissa,
  output logic signed [7:0]                 res_exponent,
  output logic                              res_maker,
  output logic                              res_final
);
  import sov_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int PW = $clog2(BUFFER_DEPTH + SEARCH_WINDOW + 16);

  scan_state_t state;
  scan_state_t state_next;

  logic [CW-1:0]    cnt;
  logic [PW-1:0]    ptr;
  logic [PW-1:0]    endp;
  logic [PW-1:0]    vstart;
  logic             have;
  logic [47:0]      hist;
  logic [IDX_W-1:0] k;
  logic [2:0]       found;
  logic [PW-1:0]    at [NUM_CODES];
  logic [7:0]       expo_cur;
  logic [63:0]      acc;
  logic [3:0]       nlen;
  logic [3:0]       nleft;

  logic [2:0]       present;
  logic [63:0]      mant [NUM_CODES];
  logic [7:0]       expo [NUM_CODES];
  logic             maker;

  logic [PW-1:0]    cnt_p;
  logic [PW-1:0]    ptr1;
  logic [PW-1:0]    win_end;
  logic [3:0]       tag_len;
  logic [63:0]      acc_next;

  assign cnt_p    = PW'(cnt);
  assign ptr1     = ptr + 1'b1;
  assign win_end  = at[k] + PW'(SEARCH_WINDOW);
  assign tag_len  = int_len(rd_data);
  assign acc_next = {acc[55:0], rd_data};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) state_next = cmd_clr ? S_IDLE : S_LOC;
      end
      S_LOC: begin
        if (ptr >= cnt_p) state_next = S_CODE;
      end
      S_CODE: begin
        state_next = found[k] ? S_SCAL : S_NEXT;
      end
      S_SCAL: begin
        if (ptr1 >= endp) begin
          state_next = S_INT;
        end else if (have && rd_data == SCALER_TAG) begin
          state_next = S_SCVAL;
        end
      end
      S_SCVAL: begin
        if (have) state_next = S_INT;
      end
      S_INT: begin
        if (ptr >= endp) begin
          state_next = S_NEXT;
        end else if (have && tag_len != 4'd0 && ptr1 + PW'(tag_len) <= cnt_p) begin
          state_next = S_INTB;
        end
      end
      S_INTB: begin
        if (have && nleft == 4'd1) state_next = S_NEXT;
      end
      S_NEXT: begin
        state_next = (k == IDX_POWER) ? S_OUT : S_CODE;
      end
      S_OUT: begin
        if (k == IDX_POWER) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy         = (state != S_IDLE);
    cmd_pop      = (state == S_IDLE) && cmd_valid;
    rd_addr      = ptr[AW-1:0];
    res_valid    = (state == S_OUT);
    res_index    = k;
    res_present  = present[k];
    res_mantissa = mant[k];
    res_exponent = expo[k];
    res_maker    = maker;
    res_final    = (state == S_OUT) && (k == IDX_POWER);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // stored values, kept across telegrams until a clear
  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      maker   <= 1'b0;
      for (int i = 0; i < NUM_CODES; i++) begin
        mant[i] <= '0;
        expo[i] <= '0;
      end
    end else begin
      if (state == S_IDLE && cmd_valid && cmd_clr) begin
        present <= '0;
        maker   <= 1'b0;
        for (int i = 0; i < NUM_CODES; i++) begin
          mant[i] <= '0;
          expo[i] <= '0;
        end
      end
      if (state == S_LOC && ptr < cnt_p && have && ptr >= PW'(2)
          && {hist[15:0], rd_data} == MAKER_MARK) begin
        maker <= 1'b1;
      end
      if (state == S_CODE && found[k]) begin
        present[k] <= 1'b1;
      end
      if (state == S_INTB && have && nleft == 4'd1) begin
        mant[k] <= sext(acc_next, nlen);
        expo[k] <= expo_cur;
      end
    end
  end

  // walk control and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      have  <= 1'b0;
      k     <= '0;
      found <= '0;
      ptr   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid && !cmd_clr) begin
            cnt   <= cmd_cnt;
            ptr   <= '0;
            have  <= 1'b0;
            found <= '0;
            k     <= '0;
          end
        end
        // one pass over the telegram for first code positions and maker bytes
        S_LOC: begin
          if (ptr < cnt_p) begin
            if (!have) begin
              have <= 1'b1;
            end else begin
              for (int c = 0; c < NUM_CODES; c++) begin
                if (!found[c] && ptr >= PW'(CODE_LEN - 1)
                    && {hist, rd_data} == CODE_TAB[c]) begin
                  found[c] <= 1'b1;
                  at[c]    <= ptr - PW'(CODE_LEN - 1);
                end
              end
              hist <= {hist[39:0], rd_data};
              ptr  <= ptr1;
              have <= 1'b0;
            end
          end
        end
        // window set-up for one code
        S_CODE: begin
          if (found[k]) begin
            ptr      <= at[k] + PW'(CODE_LEN);
            vstart   <= at[k] + PW'(CODE_LEN);
            endp     <= (win_end > cnt_p) ? cnt_p : win_end;
            expo_cur <= '0;
            have     <= 1'b0;
          end
        end
        // scaler tag search
        S_SCAL: begin
          if (ptr1 >= endp) begin
            ptr  <= vstart;
            have <= 1'b0;
          end else if (!have) begin
            have <= 1'b1;
          end else begin
            ptr  <= ptr1;
            have <= 1'b0;
          end
        end
        // scaler value byte
        S_SCVAL: begin
          if (!have) begin
            have <= 1'b1;
          end else begin
            expo_cur <= rd_data;
            ptr      <= ptr1;
            have     <= 1'b0;
          end
        end
        // integer tag search
        S_INT: begin
          if (ptr < endp) begin
            if (!have) begin
              have <= 1'b1;
            end else begin
              nlen  <= tag_len;
              nleft <= tag_len;
              acc   <= '0;
              ptr   <= ptr1;
              have  <= 1'b0;
            end
          end
        end
        // integer payload bytes, big endian
        S_INTB: begin
          if (!have) begin
            have <= 1'b1;
          end else begin
            acc   <= acc_next;
            nleft <= nleft - 1'b1;
            ptr   <= ptr1;
            have  <= 1'b0;
          end
        end
        S_NEXT: begin
          k <= (k == IDX_POWER) ? IDX_IMPORT : k + 1'b1;
        end
        S_OUT: begin
          k <= (k == IDX_POWER) ? IDX_IMPORT : k + 1'b1;
        end
        default: begin
          have <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* sv/sml_obis_value_extractor_core.sv */
// top level of the sml obis value extractor
//
//  channel  | handshake            | payload
//  request  | start, busy          | action, data_byte, last
//  result   | result_valid (1 cyc) | code_index, code_present, value_mantissa,
//           |                      | decimal_exponent, maker_seen, final_result
//
// a telegram byte or a clear is taken when start is high and busy is low; bytes load at
// one per cycle while busy stays low. on the final byte the scan runs over the single
// read port of the byte ram with registered read: a pass over the telegram for the codes,
// then a scaler and integer search in the window after each code found, then three
// results. busy is high from the final byte until the last result has gone, and
// for one cycle after a clear while the scan engine takes it from the queue.
// reset clears the loader count, the queue, stored values and flags; no ram clearing.
// results cannot be stalled: each shows for exactly one cycle.
module sml_obis_value_extractor_core #(
  parameter int BUFFER_DEPTH  = sov_pkg::DEF_BUFFER_DEPTH,
  parameter int SEARCH_WINDOW = sov_pkg::DEF_SEARCH_WINDOW
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      action,
  input  logic [7:0]                data_byte,
  input  logic                      last,
  output logic                      result_valid,
  output logic [sov_pkg::IDX_W-1:0] code_index,
  output logic                      code_present,
  output logic signed [63:0]        value_mantissa,
  output logic signed [7:0]         decimal_exponent,
  output logic                      maker_seen,
  output logic                      final_result
);
  import sov_pkg::*;

  `include "sml_obis_value_extractor_core_assert.svh"

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);

  logic          accept;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic          cmd_push;
  logic          push_clr;
  logic [CW-1:0] push_cnt;
  logic          cmd_pop;
  logic [CW:0]   cmd_head;
  logic          q_empty;
  logic          q_full;
  logic          scan_busy;

  // new requests wait until the scan and its queue are drained
  assign busy   = scan_busy || !q_empty;
  assign accept = start && !busy;

  sov_front #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .action   (action),
    .data_byte(data_byte),
    .last     (last),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .cmd_push (cmd_push),
    .cmd_clr  (push_clr),
    .cmd_cnt  (push_cnt)
  );

  sov_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  sov_cmd_q #(
    .WIDTH(CW + 1),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (cmd_push),
    .din  ({push_clr, push_cnt}),
    .pop  (cmd_pop),
    .dout (cmd_head),
    .empty(q_empty),
    .full (q_full)
  );

  sov_scan #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .SEARCH_WINDOW(SEARCH_WINDOW)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (!q_empty),
    .cmd_clr     (cmd_head[CW]),
    .cmd_cnt     (cmd_head[CW-1:0]),
    .cmd_pop     (cmd_pop),
    .rd_addr     (ram_raddr),
    .rd_data     (ram_rdata),
    .busy        (scan_busy),
    .res_valid   (result_valid),
    .res_index   (code_index),
    .res_present (code_present),
    .res_mantissa(value_mantissa),
    .res_exponent(decimal_exponent),
    .res_maker   (maker_seen),
    .res_final   (final_result)
  );

  // checks
  `SOV_ASSERT(a_res_while_busy, clk, rst, result_valid |-> busy, "result while not busy")
  `SOV_ASSERT(a_final_is_power, clk, rst, result_valid && final_result |-> code_index == IDX_POWER, "final result not on power code")
  `SOV_ASSERT(a_results_run, clk, rst, result_valid && !final_result |=> result_valid, "result run broken")
  `SOV_ASSERT(a_no_push_full, clk, rst, cmd_push |-> !q_full, "push into full queue")

endmodule
